FILE: hdl/nac_pkg.sv
// shared types, constants and codes of the ntc average and convert unit
package nac_pkg;

    localparam int SAMPLES_DEF = 64;
    localparam int ADC_BITS_DEF = 12;

    localparam int SAMPLE_W = 12;
    localparam int MV_W = 13;
    localparam int RES_W = 20;
    localparam int ATEMP_W = 15;
    localparam int BETA_W = 14;
    localparam int TEMP_W = 16;
    localparam int FAULT_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int DIV_W = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int FRAC = 28;
    localparam int LOG_XW = 33;
    localparam int LOG_EW = 6;
    localparam int LOG_MW = FRAC + 1;
    localparam int LOG_RW = LOG_EW + FRAC;
    localparam int LOG_CNT_W = 5;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    localparam logic [15:0] KELVIN_CENTI = 16'd27315;
    localparam logic [TEMP_W-1:0] TEMP_HOT = 16'sd20000;
    localparam logic [TEMP_W-1:0] TEMP_COLD = -16'sd10000;
    localparam logic [DIV_W-1:0] TK_MAX = 64'd47315;
    localparam logic [DIV_W-1:0] TK_MIN = 64'd17315;

    localparam logic [MV_W-1:0] RAIL_RST = 13'd3330;
    localparam logic [RES_W-1:0] FIXED_RST = 20'd9810;
    localparam logic [RES_W-1:0] ANCHOR_R_RST = 20'd8100;
    localparam logic [ATEMP_W-1:0] ANCHOR_T_RST = 15'd2700;
    localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;
    localparam logic [MV_W-1:0] SHORT_RST = 13'd3250;
    localparam logic [MV_W-1:0] OPEN_RST = 13'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAIL     = 3'd0,
        REG_FIXED    = 3'd1,
        REG_ANCHOR_R = 3'd2,
        REG_ANCHOR_T = 3'd3,
        REG_BETA     = 3'd4,
        REG_SHORT    = 3'd5,
        REG_OPEN     = 3'd6
    } reg_idx_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_OK    = 2'd0,
        FAULT_OPEN  = 2'd1,
        FAULT_SHORT = 2'd2
    } fault_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LD_MEAN,
        OP_MEAN_RAIL,
        OP_LD_MV,
        OP_PROD,
        OP_CLASS,
        OP_LOG_A,
        OP_LD_LA,
        OP_LOG_B,
        OP_LD_LB,
        OP_MAG,
        OP_MULH,
        OP_MULL,
        OP_LQ,
        OP_DEN,
        OP_DIV_T,
        OP_LD_T,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   take;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic fill;
        logic div_done;
        logic log_done;
        logic is_short;
        logic is_open;
        logic a_zero;
        logic b_zero;
        logic d_nonpos;
    } status_t;

endpackage

FILE: hdl/nac_in_if.sv
// sample input channel
interface nac_in_if;
    import nac_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                read_ok;

    modport source (output valid, output sample, output read_ok, input ready);
    modport sink (input valid, input sample, input read_ok, output ready);
endinterface

FILE: hdl/nac_out_if.sv
// result output channel
interface nac_out_if;
    import nac_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MV_W-1:0]          avg_mv;
    logic signed [TEMP_W-1:0] temp_centi_c;
    logic [FAULT_W-1:0]       fault_code;

    modport source (output valid, output avg_mv, output temp_centi_c, output fault_code,
                    input ready);
    modport sink (input valid, input avg_mv, input temp_centi_c, input fault_code,
                  output ready);
endinterface

FILE: hdl/nac_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module nac_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nac_pkg::DIV_W-1:0] num,
    input  logic [nac_pkg::DIV_W-1:0] den,
    output logic [nac_pkg::DIV_W-1:0] quot,
    output logic                      done
);
    import nac_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [DIV_W-1:0]     r_reg;
    logic [DIV_W-1:0]     d_reg;

    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 ge;

    assign shifted = {r_reg, q_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIV_W-2:0], ge};
            r_reg <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

FILE: hdl/nac_log.sv
// iterative log2 in q28: normalising shift then one squaring per fraction bit
module nac_log (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nac_pkg::LOG_XW-1:0] x,
    output logic [nac_pkg::LOG_RW-1:0] result,
    output logic                       done
);
    import nac_pkg::*;

    logic                 norm_reg;
    logic                 sq_reg;
    logic                 done_reg;
    logic [LOG_CNT_W-1:0] cnt_reg;
    logic [LOG_XW-1:0]    x_reg;
    logic [LOG_EW-1:0]    e_reg;
    logic [LOG_MW-1:0]    m_reg;
    logic [FRAC-1:0]      f_reg;

    logic [2*LOG_MW-1:0]  sq;
    logic [LOG_MW:0]      ms;

    assign sq = m_reg * m_reg;
    assign ms = sq[2*LOG_MW-1:FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg <= 1'b0;
            sq_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                norm_reg <= 1'b1;
                sq_reg   <= 1'b0;
            end
            else if (norm_reg && x_reg[LOG_XW-1])
            begin
                norm_reg <= 1'b0;
                sq_reg   <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (sq_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LOG_CNT_W'(FRAC - 1))
                begin
                    sq_reg   <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            e_reg <= LOG_EW'(LOG_XW - 1);
        end
        else if (norm_reg)
        begin
            if (x_reg[LOG_XW-1])
            begin
                m_reg <= x_reg[LOG_XW-1:LOG_XW-LOG_MW];
                f_reg <= '0;
            end
            else
            begin
                x_reg <= {x_reg[LOG_XW-2:0], 1'b0};
                e_reg <= e_reg - 1'b1;
            end
        end
        else if (sq_reg)
        begin
            if (ms[LOG_MW])
            begin
                m_reg <= ms[LOG_MW:1];
            end
            else
            begin
                m_reg <= ms[LOG_MW-1:0];
            end
            f_reg <= {f_reg[FRAC-2:0], ms[LOG_MW]};
        end
    end

    assign result = {e_reg, f_reg};
    assign done   = done_reg;
endmodule

FILE: hdl/nac_datapath.sv
// datapath: configuration, accumulator, conversion arithmetic and result register
module nac_datapath #(
    parameter int SAMPLES_PER_RESULT = nac_pkg::SAMPLES_DEF,
    parameter int ADC_BITS           = nac_pkg::ADC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nac_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [nac_pkg::SAMPLE_W-1:0]      sample,
    input  logic                              read_ok,
    input  nac_pkg::cmd_t                     cmd,
    output nac_pkg::status_t                  st,
    output logic [nac_pkg::MV_W-1:0]          avg_mv,
    output logic signed [nac_pkg::TEMP_W-1:0] temp_centi_c,
    output logic [nac_pkg::FAULT_W-1:0]       fault_code
);
    import nac_pkg::*;

    localparam int SUM_W = ADC_BITS + $clog2(SAMPLES_PER_RESULT);
    localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
    localparam int EXT_W = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam int MR_W  = ADC_BITS + MV_W;

    // floor division by constants through a rounded-up reciprocal
    localparam int MEAN_SH  = SUM_W + $clog2(SAMPLES_PER_RESULT);
    localparam int MEAN_K_W = SUM_W + 2;
    localparam longint unsigned MEAN_K =
        ((64'd1 << MEAN_SH) + 64'(SAMPLES_PER_RESULT) - 64'd1) / 64'(SAMPLES_PER_RESULT);
    localparam int FULL_CODE = (1 << ADC_BITS) - 1;
    localparam int MV_SH     = MR_W + ADC_BITS;
    localparam int MV_K_W    = MR_W + 2;
    localparam longint unsigned MV_K =
        ((64'd1 << MV_SH) + 64'(FULL_CODE) - 64'd1) / 64'(FULL_CODE);

    logic [MV_W-1:0]    rail_reg;
    logic [RES_W-1:0]   fixed_reg;
    logic [RES_W-1:0]   anchor_r_reg;
    logic [ATEMP_W-1:0] anchor_t_reg;
    logic [BETA_W-1:0]  beta_reg;
    logic [MV_W-1:0]    short_reg;
    logic [MV_W-1:0]    open_reg;

    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TEMP_W-1:0]  last_reg;

    logic [ADC_BITS-1:0]    mean_reg;
    logic [MR_W-1:0]        mr_reg;
    logic [MV_W-1:0]        mv_reg;
    logic [LOG_XW-1:0]      a_reg;
    logic [LOG_XW-1:0]      b_reg;
    logic [LOG_RW-1:0]      la_reg;
    logic [LOG_RW-1:0]      lb_reg;
    logic [LOG_RW-1:0]      mag_reg;
    logic                   neg_reg;
    logic [61:0]            p_reg;
    logic signed [30:0]     lq_reg;
    logic signed [48:0]     d_reg;
    logic [36:0]            n_reg;
    logic [FAULT_W-1:0]     fault_reg;
    logic [MV_W-1:0]        avg_out_reg;
    logic [TEMP_W-1:0]      temp_out_reg;
    logic [FAULT_W-1:0]     fault_out_reg;

    logic [EXT_W-1:0]            sample_ext;
    logic [ADC_BITS-1:0]         sample_m;
    logic [SUM_W+MEAN_K_W-1:0]   mean_prod;
    logic [MR_W+MV_K_W-1:0]      mv_prod;
    logic [16:0]                 tc_wide;
    logic [15:0]                 tc;
    logic [20:0]                 beta100;
    logic [44:0]                 scale;
    logic signed [47:0]          lqtc;
    logic signed [48:0]          d_sum;
    logic [29:0]                 pq;

    logic                div_start;
    logic [DIV_W-1:0]    div_num;
    logic [DIV_W-1:0]    div_den;
    logic [DIV_W-1:0]    div_q;
    logic                div_done;
    logic                log_start;
    logic [LOG_XW-1:0]   log_x;
    logic [LOG_RW-1:0]   log_r;
    logic                log_done;
    logic [TEMP_W-1:0]   temp_sat;

    assign sample_ext = EXT_W'(sample);
    assign sample_m   = sample_ext[ADC_BITS-1:0];
    assign mean_prod  = sum_reg * MEAN_K_W'(MEAN_K);
    assign mv_prod    = mr_reg * MV_K_W'(MV_K);
    assign tc_wide    = {{2{anchor_t_reg[ATEMP_W-1]}}, anchor_t_reg} + {1'b0, KELVIN_CENTI};
    assign tc         = tc_wide[15:0];
    assign beta100    = 21'(beta_reg) * 21'd100;
    assign scale      = {beta100, 24'd0};
    assign lqtc       = lq_reg * $signed({1'b0, tc});
    assign d_sum      = $signed({4'b0000, scale}) + {lqtc[47], lqtc};
    assign pq         = p_reg[61:32];

    assign st.fill     = read_ok && (cnt_reg == CNT_W'(SAMPLES_PER_RESULT - 1));
    assign st.div_done = div_done;
    assign st.log_done = log_done;
    assign st.is_short = mv_reg >= short_reg;
    assign st.is_open  = mv_reg <= open_reg;
    assign st.a_zero   = a_reg == '0;
    assign st.b_zero   = b_reg == '0;
    assign st.d_nonpos = d_reg[48] || (d_reg == '0);

    assign div_start = (cmd.op == OP_DIV_T) && !st.d_nonpos;
    assign div_num   = DIV_W'({n_reg, 25'd0}) + DIV_W'(d_reg[47:0]);
    assign div_den   = DIV_W'({d_reg[47:0], 1'b0});

    assign log_start = (cmd.op == OP_LOG_A) || (cmd.op == OP_LOG_B);
    assign log_x     = (cmd.op == OP_LOG_B) ? b_reg : a_reg;

    always_comb
    begin
        priority if (div_q > TK_MAX)
        begin
            temp_sat = TEMP_HOT;
        end
        else if (div_q < TK_MIN)
        begin
            temp_sat = TEMP_COLD;
        end
        else
        begin
            temp_sat = div_q[15:0] - KELVIN_CENTI;
        end
    end

    nac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    nac_log u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .result (log_r),
        .done   (log_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_reg     <= RAIL_RST;
            fixed_reg    <= FIXED_RST;
            anchor_r_reg <= ANCHOR_R_RST;
            anchor_t_reg <= ANCHOR_T_RST;
            beta_reg     <= BETA_RST;
            short_reg    <= SHORT_RST;
            open_reg     <= OPEN_RST;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            last_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RAIL:     rail_reg     <= cfg_data[MV_W-1:0];
                    REG_FIXED:    fixed_reg    <= cfg_data[RES_W-1:0];
                    REG_ANCHOR_R: anchor_r_reg <= cfg_data[RES_W-1:0];
                    REG_ANCHOR_T: anchor_t_reg <= cfg_data[ATEMP_W-1:0];
                    REG_BETA:     beta_reg     <= cfg_data[BETA_W-1:0];
                    REG_SHORT:    short_reg    <= cfg_data[MV_W-1:0];
                    REG_OPEN:     open_reg     <= cfg_data[MV_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.take)
            begin
                if (read_ok)
                begin
                    sum_reg <= sum_reg + SUM_W'(sample_m);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            unique case (cmd.op)
                OP_LD_MEAN:
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                OP_CLASS:
                begin
                    if (!st.is_short && !st.is_open)
                    begin
                        if (st.a_zero)
                        begin
                            last_reg <= TEMP_HOT;
                        end
                        else if (st.b_zero)
                        begin
                            last_reg <= TEMP_COLD;
                        end
                    end
                end
                OP_DIV_T:
                begin
                    if (st.d_nonpos)
                    begin
                        last_reg <= TEMP_HOT;
                    end
                end
                OP_LD_T:
                begin
                    last_reg <= temp_sat;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LD_MEAN:   mean_reg <= mean_prod[MEAN_SH+ADC_BITS-1:MEAN_SH];
            OP_MEAN_RAIL: mr_reg   <= mean_reg * rail_reg;
            OP_LD_MV:     mv_reg   <= mv_prod[MV_SH+MV_W-1:MV_SH];
            OP_PROD:
            begin
                a_reg <= fixed_reg * (rail_reg - mv_reg);
                b_reg <= mv_reg * anchor_r_reg;
            end
            OP_CLASS:
            begin
                priority if (st.is_short)
                begin
                    fault_reg <= FAULT_SHORT;
                end
                else if (st.is_open)
                begin
                    fault_reg <= FAULT_OPEN;
                end
                else
                begin
                    fault_reg <= FAULT_OK;
                end
            end
            OP_LD_LA:   la_reg <= log_r;
            OP_LD_LB:   lb_reg <= log_r;
            OP_MAG:
            begin
                neg_reg <= la_reg < lb_reg;
                mag_reg <= (la_reg < lb_reg) ? (lb_reg - la_reg) : (la_reg - lb_reg);
            end
            OP_MULH:    p_reg <= {45'(mag_reg[33:17] * LN2_Q28), 17'd0};
            OP_MULL:    p_reg <= p_reg + 62'(mag_reg[16:0] * LN2_Q28);
            OP_LQ:      lq_reg <= neg_reg ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
            OP_DEN:
            begin
                d_reg <= d_sum;
                n_reg <= tc * beta100;
            end
            OP_OUT:
            begin
                avg_out_reg   <= mv_reg;
                temp_out_reg  <= last_reg;
                fault_out_reg <= fault_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign avg_mv       = avg_out_reg;
    assign temp_centi_c = temp_out_reg;
    assign fault_code   = fault_out_reg;
endmodule

FILE: hdl/nac_ctrl.sv
// controller: sequences accumulation, conversion steps and result transfer
module nac_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  nac_pkg::status_t st,
    output nac_pkg::cmd_t    cmd
);
    import nac_pkg::*;

    typedef enum logic [17:0] {
        S_ACC    = 18'h00001,
        S_MEAN   = 18'h00002,
        S_RAIL   = 18'h00004,
        S_MV     = 18'h00008,
        S_PROD   = 18'h00010,
        S_CLASS  = 18'h00020,
        S_LOGA   = 18'h00040,
        S_LOGA_W = 18'h00080,
        S_LOGB   = 18'h00100,
        S_LOGB_W = 18'h00200,
        S_MAG    = 18'h00400,
        S_MULH   = 18'h00800,
        S_MULL   = 18'h01000,
        S_LQ     = 18'h02000,
        S_DEN    = 18'h04000,
        S_DIVT   = 18'h08000,
        S_DIVT_W = 18'h10000,
        S_OUT    = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;

    assign in_ready = state_reg == S_ACC;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.take   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.take = in_fire;
                if (in_fire && st.fill)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.op     = OP_LD_MEAN;
                state_next = S_RAIL;
            end
            S_RAIL:
            begin
                cmd.op     = OP_MEAN_RAIL;
                state_next = S_MV;
            end
            S_MV:
            begin
                cmd.op     = OP_LD_MV;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.op     = OP_PROD;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.op = OP_CLASS;
                if (st.is_short || st.is_open || st.a_zero || st.b_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LOGA;
                end
            end
            S_LOGA:
            begin
                cmd.op     = OP_LOG_A;
                state_next = S_LOGA_W;
            end
            S_LOGA_W:
            begin
                if (st.log_done)
                begin
                    cmd.op     = OP_LD_LA;
                    state_next = S_LOGB;
                end
            end
            S_LOGB:
            begin
                cmd.op     = OP_LOG_B;
                state_next = S_LOGB_W;
            end
            S_LOGB_W:
            begin
                if (st.log_done)
                begin
                    cmd.op     = OP_LD_LB;
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = S_MULH;
            end
            S_MULH:
            begin
                cmd.op     = OP_MULH;
                state_next = S_MULL;
            end
            S_MULL:
            begin
                cmd.op     = OP_MULL;
                state_next = S_LQ;
            end
            S_LQ:
            begin
                cmd.op     = OP_LQ;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                cmd.op     = OP_DEN;
                state_next = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.op     = OP_DIV_T;
                state_next = st.d_nonpos ? S_OUT : S_DIVT_W;
            end
            S_DIVT_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_LD_T;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_div_done_waiting : assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == S_DIVT_W))
        else $error("divider finished outside a wait state");

    a_log_done_waiting : assert property (@(posedge clk) disable iff (!rst_n)
        st.log_done |-> (state_reg == S_LOGA_W || state_reg == S_LOGB_W))
        else $error("log unit finished outside a wait state");

    a_fill_starts_mean : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && st.fill) |=> (state_reg == S_MEAN && !in_ready))
        else $error("completed average did not start conversion");

    a_out_load_free : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(state_reg == S_OUT)
                                       || state_reg != S_ACC))
        else $error("pending result overwritten");
`endif
endmodule

FILE: hdl/ntc_average_and_convert_unit.sv
// top level of the ntc average and convert unit
// Samples are taken one per clock while averaging. The transfer that completes an average
// stalls the input while the conversion runs: it forms the mean, the rail product and the
// millivolt value by reciprocal multiplication, forms the resistance products and classifies
// the reading, so a fault reading, or a reading with a zero resistance product, goes straight
// to the output step. A good reading then runs the log2 unit twice, each pass taking one
// normalising shift per leading zero of its 33-bit operand and one squaring per fraction bit,
// then scales the log difference, forms the denominator and runs the division before the
// output step; a nonpositive denominator skips the division. One result may wait in the output
// register while the next average is being collected; a conversion that finishes while it
// still waits holds the input until that result is taken.
module ntc_average_and_convert_unit #(
    parameter int SAMPLES_PER_RESULT = nac_pkg::SAMPLES_DEF,
    parameter int ADC_BITS           = nac_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nac_pkg::CFG_DATA_W-1:0] cfg_data,
    nac_in_if.sink                         in_ch,
    nac_out_if.source                      out_ch
);
    import nac_pkg::*;

    cmd_t    cmd;
    status_t st;

    nac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    nac_datapath #(
        .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
        .ADC_BITS           (ADC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (in_ch.sample),
        .read_ok      (in_ch.read_ok),
        .cmd          (cmd),
        .st           (st),
        .avg_mv       (out_ch.avg_mv),
        .temp_centi_c (out_ch.temp_centi_c),
        .fault_code   (out_ch.fault_code)
    );
endmodule

FILE: verif/ntc_average_and_convert_unit_tb.sv
// testbench for the ntc average and convert unit: random sample blocks, scoreboard check
`timescale 1ns / 1ps

module ntc_average_and_convert_unit_tb;
    import nac_pkg::*;

    localparam int BLOCK = 64;
    localparam int FULL_CODE = 4095;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [MV_W-1:0]          avg_mv;
        logic signed [TEMP_W-1:0] temp_centi_c;
        fault_t                   fault_code;
    } reading_t;

    class temp_scoreboard;
        logic [MV_W-1:0]           rail;
        logic [RES_W-1:0]          fixed_r;
        logic [RES_W-1:0]          anchor_r;
        logic signed [ATEMP_W-1:0] anchor_t;
        logic [BETA_W-1:0]         beta;
        logic [MV_W-1:0]           short_mv;
        logic [MV_W-1:0]           open_mv;
        logic [17:0]               sum;
        int unsigned               count;
        logic signed [TEMP_W-1:0]  held_temp;
        reading_t                  pending_readings[$];
        int                        errors;

        function new();
            rail = RAIL_RST;
            fixed_r = FIXED_RST;
            anchor_r = ANCHOR_R_RST;
            anchor_t = ANCHOR_T_RST;
            beta = BETA_RST;
            short_mv = SHORT_RST;
            open_mv = OPEN_RST;
            sum = 0;
            count = 0;
            held_temp = 0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_RAIL:     rail = v[MV_W-1:0];
                REG_FIXED:    fixed_r = v[RES_W-1:0];
                REG_ANCHOR_R: anchor_r = v[RES_W-1:0];
                REG_ANCHOR_T: anchor_t = v[ATEMP_W-1:0];
                REG_BETA:     beta = v[BETA_W-1:0];
                REG_SHORT:    short_mv = v[MV_W-1:0];
                REG_OPEN:     open_mv = v[MV_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned log2_fix(longint unsigned x);
            int unsigned e;
            longint unsigned t;
            longint unsigned m;
            longint unsigned r;
            e = 0;
            t = x;
            while (t > 1)
            begin
                t = t >> 1;
                e++;
            end
            m = (e >= FRAC) ? (x >> (e - FRAC)) : (x << (FRAC - e));
            r = longint'(e) << FRAC;
            for (int i = FRAC - 1; i >= 0; i--)
            begin
                m = (m * m) >> FRAC;
                if (m >= (64'd2 << FRAC))
                begin
                    m = m >> 1;
                    r = r | (64'd1 << i);
                end
            end
            return r;
        endfunction

        function logic signed [TEMP_W-1:0] ntc_temp(logic [MV_W-1:0] mv);
            longint unsigned a;
            longint unsigned b;
            longint unsigned la;
            longint unsigned lb;
            longint unsigned mag;
            longint lq;
            longint tc;
            longint scale;
            longint d;
            longint n;
            longint t;
            a = longint'(fixed_r) * (longint'(rail) - longint'(mv));
            b = longint'(mv) * longint'(anchor_r);
            if (a == 0)
                return 16'sd20000;
            if (b == 0)
                return -16'sd10000;
            la = log2_fix(a);
            lb = log2_fix(b);
            mag = (la < lb) ? (lb - la) : (la - lb);
            lq = longint'((mag * 64'd186065279) >> 32);
            if (la < lb)
                lq = -lq;
            tc = longint'(anchor_t) + 27315;
            scale = longint'(beta) * 100 * (64'sd1 << 24);
            d = scale + lq * tc;
            if (d <= 0)
                return 16'sd20000;
            n = tc * scale;
            t = (2 * n + d) / (2 * d) - 27315;
            if (t > 20000)
                t = 20000;
            if (t < -10000)
                t = -10000;
            return t[TEMP_W-1:0];
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s, logic ok);
            longint unsigned mean;
            longint unsigned mv;
            reading_t rd;
            if (!ok)
            begin
                sum = 0;
                count = 0;
                return;
            end
            sum = sum + s;
            count++;
            if (count < BLOCK)
                return;
            mean = sum / BLOCK;
            sum = 0;
            count = 0;
            mv = (mean * rail) / FULL_CODE;
            if (mv > 64'h1FFF)
                mv = 64'h1FFF;
            rd.avg_mv = mv[MV_W-1:0];
            if (rd.avg_mv >= short_mv)
                rd.fault_code = FAULT_SHORT;
            else if (rd.avg_mv <= open_mv)
                rd.fault_code = FAULT_OPEN;
            else
            begin
                rd.fault_code = FAULT_OK;
                held_temp = ntc_temp(rd.avg_mv);
            end
            rd.temp_centi_c = held_temp;
            pending_readings.push_back(rd);
        endfunction

        function void check_result(logic [MV_W-1:0] mv, logic signed [TEMP_W-1:0] temp,
                                   logic [FAULT_W-1:0] fault);
            reading_t rd;
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result transfer avg_mv=%0d", mv);
                errors++;
                return;
            end
            rd = pending_readings.pop_front();
            if (mv !== rd.avg_mv)
            begin
                $error("avg_mv expected %0d actual %0d", rd.avg_mv, mv);
                errors++;
            end
            if (temp !== rd.temp_centi_c)
            begin
                $error("temp_centi_c expected %0d actual %0d", rd.temp_centi_c, temp);
                errors++;
            end
            if (fault !== rd.fault_code)
            begin
                $error("fault_code expected %0d actual %0d", rd.fault_code, fault);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;
    temp_scoreboard sb;

    nac_in_if in_ch();
    nac_out_if out_ch();

    ntc_average_and_convert_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.avg_mv, out_ch.temp_centi_c, out_ch.fault_code);
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_regs(int rail, int fixed_r, int anchor_r, int anchor_t, int beta,
                             int short_mv, int open_mv);
        write_reg(REG_RAIL, CFG_DATA_W'(rail));
        write_reg(REG_FIXED, CFG_DATA_W'(fixed_r));
        write_reg(REG_ANCHOR_R, CFG_DATA_W'(anchor_r));
        write_reg(REG_ANCHOR_T, CFG_DATA_W'(anchor_t & 32'h7FFF));
        write_reg(REG_BETA, CFG_DATA_W'(beta));
        write_reg(REG_SHORT, CFG_DATA_W'(short_mv));
        write_reg(REG_OPEN, CFG_DATA_W'(open_mv));
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic ok);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.sample = s;
        in_ch.read_ok = ok;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        sb.note_sample(s, ok);
    endtask

    // one average worth of samples around base; fail_at < BLOCK inserts a failed read
    task automatic send_block(int base, int spread, int fail_at);
        int v;
        for (int i = 0; i < BLOCK; i++)
        begin
            if (i == fail_at)
                send_sample(SAMPLE_W'($urandom_range(FULL_CODE)), 1'b0);
            v = base + $urandom_range(2 * spread) - spread;
            if (v < 0)
                v = 0;
            if (v > FULL_CODE)
                v = FULL_CODE;
            send_sample(SAMPLE_W'(v), 1'b1);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int blocks);
        for (int k = 0; k < blocks; k++)
        begin
            if ($urandom_range(9) == 0)
                send_sample(SAMPLE_W'($urandom_range(FULL_CODE)), 1'($urandom_range(1)));
            send_block($urandom_range(FULL_CODE), $urandom_range(64),
                       ($urandom_range(9) == 0) ? $urandom_range(BLOCK - 1) : BLOCK);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RAIL;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.read_ok = 1'b0;
        send_idle_pct = 21;
        recv_stall_pct = 86;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed under reset settings
        send_block(0, 0, BLOCK);
        send_block(FULL_CODE, 0, 10);
        send_block(2048, 0, BLOCK);
        send_block(1500, 40, BLOCK);
        drain();

        load_regs(3330, 9810, 8100, 2700, 3950, 3250, 50);
        random_phase(7);
        drain();

        // low extremes: full scale reading equals the rail
        send_idle_pct = 86;
        recv_stall_pct = 21;
        load_regs(1000, 100, 1000000, -5000, 1000, 5000, 0);
        send_block(FULL_CODE, 0, BLOCK);
        send_block(0, 0, BLOCK);
        random_phase(6);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_regs(5000, 1000000, 100, 10000, 10000, 4900, 100);
        send_block(4000, 0, BLOCK);
        random_phase(6);
        drain();

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
